FILE: hdl/aus_pkg.sv
`default_nettype none

package aus_pkg;

  // Widths of the result fields.
  localparam int OUT_POS_W = 32;
  localparam int OUT_TS_W  = 48;

  // Timestamp step register.
  localparam int                STEP_W     = 10;
  localparam logic [STEP_W-1:0] STEP_RESET = 10'd33;

  // Byte values and NAL header fields.
  localparam logic [7:0] BYTE_ZERO     = 8'h00;
  localparam logic [7:0] BYTE_ONE      = 8'h01;
  localparam logic [4:0] NAL_TYPE_MASK = 5'h1f;
  localparam logic [4:0] NAL_SLICE     = 5'd1;
  localparam logic [4:0] NAL_IDR       = 5'd5;

  // Zero-run counter values.
  localparam logic [1:0] ZRUN_THREE_BYTE = 2'd2;
  localparam logic [1:0] ZRUN_FOUR_BYTE  = 2'd3;

  // Result kinds.
  localparam logic KIND_PACKET     = 1'b0;
  localparam logic KIND_NO_PICTURE = 1'b1;

  // One result word.
  typedef struct packed {
    logic                 kind;
    logic [OUT_POS_W-1:0] start;
    logic [OUT_POS_W-1:0] length;
    logic [OUT_TS_W-1:0]  ts;
  } result_t;

  // Everything one input byte produces: one or two result words.
  typedef struct packed {
    logic    two;
    result_t first;
    result_t second;
  } event_t;

  // A picture (VCL) NAL is a coded slice or an IDR slice.
  function automatic logic is_picture(input logic [7:0] hdr);
    logic [4:0] nal_type;
    nal_type = hdr[4:0] & NAL_TYPE_MASK;
    return (nal_type == NAL_SLICE) || (nal_type == NAL_IDR);
  endfunction

endpackage

`default_nettype wire

FILE: hdl/aus_front.sv
`default_nettype none

module aus_front import aus_pkg::*; #(
  parameter int POSITION_BITS  = 32,
  parameter int TIMESTAMP_BITS = 48
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [STEP_W-1:0] cfg_data,
  input  wire logic              in_push,
  input  wire logic [7:0]        in_data_byte,
  input  wire logic              in_last_byte,
  input  wire logic              q_full,
  output logic                   ev_push,
  output event_t                 ev
);

  localparam int                   PB      = POSITION_BITS;
  localparam int                   TB      = TIMESTAMP_BITS;
  localparam logic [PB-1:0]        POS_MAX = {PB{1'b1}};

  // Stream state.
  logic [PB-1:0]     pos_r, pos_nxt;
  logic [PB-1:0]     pos_plus_r, pos_plus_nxt;
  logic [1:0]        zrun_r, zrun_nxt;
  logic              hdr_pend_r, hdr_pend_nxt;
  logic [PB-1:0]     code_off_r, code_off_nxt;
  logic [PB-1:0]     pkt_begin_r, pkt_begin_nxt;
  logic              has_pic_r, has_pic_nxt;
  logic              any_code_r, any_code_nxt;
  logic [7:0]        first_byte_r, first_byte_nxt;
  logic [TB-1:0]     ts_r, ts_nxt;
  logic [STEP_W-1:0] step_r;

  // Per-byte decode.
  logic              accept;
  logic              first_pic;
  logic              cut;
  logic              has_pic_a;
  logic [PB-1:0]     begin_a;
  logic              code_seen;
  logic              four;
  logic              take;
  logic [PB-1:0]     off;
  logic              any_code_b;
  logic              have_pic;
  logic              fin_pic;
  logic [7:0]        fb;
  logic [PB-1:0]     cut_len;
  logic [PB-1:0]     fin_start;
  logic [PB-1:0]     fin_len;
  logic [TB-1:0]     ts_one;
  logic [TB-1:0]     ts_two;
  result_t           cut_res;
  result_t           fin_res;

  assign accept = in_push && !q_full;

  always_comb begin
    fb        = (pos_r == '0) ? in_data_byte : first_byte_r;

    // NAL header byte right after a start code.
    first_pic = hdr_pend_r && is_picture(in_data_byte);
    cut       = first_pic && has_pic_r;
    has_pic_a = has_pic_r || first_pic;
    begin_a   = cut ? code_off_r : pkt_begin_r;

    // Start code detection; a code ending on the final byte needs four bytes.
    code_seen  = (in_data_byte == BYTE_ONE) && (zrun_r >= ZRUN_THREE_BYTE);
    four       = (zrun_r == ZRUN_FOUR_BYTE);
    take       = code_seen && (four || !in_last_byte) &&
                 (pos_r >= (four ? PB'(3) : PB'(2)));
    off        = pos_r - (four ? PB'(3) : PB'(2));
    any_code_b = any_code_r || take;

    // Length of the packet closed by a cut.
    cut_len = (code_off_r >= pkt_begin_r) ? code_off_r - pkt_begin_r : '0;

    // Packet flushed at end of stream.
    have_pic = any_code_b ? has_pic_a : is_picture(fb);
    fin_pic  = in_last_byte && have_pic;
    if (!any_code_b) begin
      fin_start = '0;
      fin_len   = pos_plus_r;
    end else if (take && !any_code_r) begin
      // First code found on the final byte: a four-byte code, one byte
      // shorter when the position has saturated.
      fin_start = off;
      fin_len   = (pos_r == POS_MAX) ? PB'(3) : PB'(4);
    end else begin
      fin_start = begin_a;
      fin_len   = (pos_plus_r >= begin_a) ? pos_plus_r - begin_a : '0;
    end

    ts_one = ts_r + TB'(step_r);
    ts_two = ts_r + TB'({step_r, 1'b0});

    cut_res.kind   = KIND_PACKET;
    cut_res.start  = OUT_POS_W'(pkt_begin_r);
    cut_res.length = OUT_POS_W'(cut_len);
    cut_res.ts     = OUT_TS_W'(ts_r);

    if (have_pic) begin
      fin_res.kind   = KIND_PACKET;
      fin_res.start  = OUT_POS_W'(fin_start);
      fin_res.length = OUT_POS_W'(fin_len);
      fin_res.ts     = OUT_TS_W'(cut ? ts_one : ts_r);
    end else begin
      fin_res.kind   = KIND_NO_PICTURE;
      fin_res.start  = '0;
      fin_res.length = '0;
      fin_res.ts     = '0;
    end

    // Word for the queue.
    ev_push   = accept && (cut || in_last_byte);
    ev.two    = cut && in_last_byte;
    ev.first  = cut ? cut_res : fin_res;
    ev.second = fin_res;
  end

  // Next stream state.
  always_comb begin
    if (cut && fin_pic) begin
      ts_nxt = ts_two;
    end else if (cut || fin_pic) begin
      ts_nxt = ts_one;
    end else begin
      ts_nxt = ts_r;
    end

    if (code_seen) begin
      zrun_nxt = 2'd0;
    end else if (in_data_byte == BYTE_ZERO) begin
      zrun_nxt = (zrun_r == ZRUN_FOUR_BYTE) ? zrun_r : zrun_r + 2'd1;
    end else begin
      zrun_nxt = 2'd0;
    end

    hdr_pend_nxt   = take;
    code_off_nxt   = take ? off : code_off_r;
    pkt_begin_nxt  = (take && !any_code_r) ? off : begin_a;
    has_pic_nxt    = has_pic_a;
    any_code_nxt   = any_code_b;
    first_byte_nxt = fb;
    pos_nxt        = pos_plus_r;
    pos_plus_nxt   = (pos_plus_r == POS_MAX) ? POS_MAX : pos_plus_r + PB'(1);

    // The final byte clears the stream state for the next stream.
    if (in_last_byte) begin
      zrun_nxt       = 2'd0;
      hdr_pend_nxt   = 1'b0;
      code_off_nxt   = '0;
      pkt_begin_nxt  = '0;
      has_pic_nxt    = 1'b0;
      any_code_nxt   = 1'b0;
      first_byte_nxt = '0;
      pos_nxt        = '0;
      pos_plus_nxt   = PB'(1);
    end
  end

  // State registers, updated on every accepted byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      pos_plus_r   <= PB'(1);
      zrun_r       <= 2'd0;
      hdr_pend_r   <= 1'b0;
      code_off_r   <= '0;
      pkt_begin_r  <= '0;
      has_pic_r    <= 1'b0;
      any_code_r   <= 1'b0;
      first_byte_r <= '0;
      ts_r         <= '0;
    end else if (accept) begin
      pos_r        <= pos_nxt;
      pos_plus_r   <= pos_plus_nxt;
      zrun_r       <= zrun_nxt;
      hdr_pend_r   <= hdr_pend_nxt;
      code_off_r   <= code_off_nxt;
      pkt_begin_r  <= pkt_begin_nxt;
      has_pic_r    <= has_pic_nxt;
      any_code_r   <= any_code_nxt;
      first_byte_r <= first_byte_nxt;
      ts_r         <= ts_nxt;
    end
  end

  // Timestamp step register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_RESET;
    end else if (cfg_we) begin
      step_r <= cfg_data;
    end
  end

`ifndef ASSERT_OFF
  // The look-ahead position is always one past the position, or saturated.
  a_pos_plus: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_plus_r == pos_r + PB'(1)) || (pos_plus_r == POS_MAX))
    else $error("aus_front: look-ahead position out of step");

  // A packet is only cut once an earlier packet holds a picture.
  a_cut_after_pic: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && cut) |-> (any_code_r && has_pic_r))
    else $error("aus_front: cut without an open picture packet");
`endif

endmodule

`default_nettype wire

FILE: hdl/aus_queue.sv
`default_nettype none

module aus_queue import aus_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire event_t din,
  output logic        full,
  input  wire logic   pop,
  output event_t      dout,
  output logic        empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  event_t        entries_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = entries_r[rd_ptr_r];

  // Pointer and fill-count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= din;
    end
  end

`ifndef ASSERT_OFF
  // The fill count never exceeds the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("aus_queue: fill count beyond depth");

  // A push with no pop grows the queue by one word.
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("aus_queue: push lost");
`endif

endmodule

`default_nettype wire

FILE: hdl/aus_back.sv
`default_nettype none

module aus_back import aus_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire event_t            q_head,
  input  wire logic              q_empty,
  output logic                   q_pop,
  input  wire logic              pop,
  output logic                   empty,
  output logic                   out_kind,
  output logic [OUT_POS_W-1:0]   out_packet_start,
  output logic [OUT_POS_W-1:0]   out_packet_length,
  output logic [OUT_TS_W-1:0]    out_timestamp,
  output logic                   out_run_last
);

  // Set while the second result of a two-result word is on the ports.
  logic    sub_r, sub_nxt;
  logic    taken;
  result_t sel;

  always_comb begin
    sel               = sub_r ? q_head.second : q_head.first;
    empty             = q_empty;
    out_kind          = sel.kind;
    out_packet_start  = sel.start;
    out_packet_length = sel.length;
    out_timestamp     = sel.ts;
    out_run_last      = !q_head.two || sub_r;
    taken             = pop && !q_empty;
    q_pop             = taken && out_run_last;
    sub_nxt           = taken ? !out_run_last : sub_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r <= 1'b0;
    end else begin
      sub_r <= sub_nxt;
    end
  end

`ifndef ASSERT_OFF
  // The second slot is only shown for a waiting two-result word.
  a_sub_valid: assert property (@(posedge clk) disable iff (!rst_n)
    sub_r |-> (!q_empty && q_head.two))
    else $error("aus_back: second slot without a two-result word");

  // Taking the first of two results keeps the word and moves to the second.
  a_first_of_two: assert property (@(posedge clk) disable iff (!rst_n)
    (taken && q_head.two && !sub_r) |=> (sub_r && !q_empty))
    else $error("aus_back: second result dropped");
`endif

endmodule

`default_nettype wire

FILE: hdl/annexb_access_unit_splitter_unit.sv
// Results of an accepted byte are registered in the event queue and shown from its head.
// Throughput: one byte per cycle in while the queue is not full; one result word per
// cycle out while pop is high and results wait. A final byte that also closes a packet
// gives two words; the event queue (QUEUE_DEPTH entries) absorbs them while bytes flow.
// Reset: synchronous, active low; clears stream state, timestamp and queue, and
// sets the timestamp step to 33.
`default_nettype none

module annexb_access_unit_splitter_unit import aus_pkg::*; #(
  parameter int POSITION_BITS  = 32,
  parameter int TIMESTAMP_BITS = 48,
  parameter int QUEUE_DEPTH    = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [STEP_W-1:0] cfg_data,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [7:0]        in_data_byte,
  input  wire logic              in_last_byte,
  output logic                   empty,
  input  wire logic              pop,
  output logic                   out_kind,
  output logic [OUT_POS_W-1:0]   out_packet_start,
  output logic [OUT_POS_W-1:0]   out_packet_length,
  output logic [OUT_TS_W-1:0]    out_timestamp,
  output logic                   out_run_last
);

  logic   q_full;
  logic   q_empty;
  logic   q_pop;
  logic   ev_push;
  event_t ev;
  event_t q_head;

  assign full = q_full;

  // Parser: classifies each byte and builds the result word.
  aus_front #(
    .POSITION_BITS  (POSITION_BITS),
    .TIMESTAMP_BITS (TIMESTAMP_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_push      (push),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .q_full       (q_full),
    .ev_push      (ev_push),
    .ev           (ev)
  );

  // Event queue between parser and result side.
  aus_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (ev_push),
    .din   (ev),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_head),
    .empty (q_empty)
  );

  // Result side: hands out one or two results per queued word.
  aus_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_head            (q_head),
    .q_empty           (q_empty),
    .q_pop             (q_pop),
    .pop               (pop),
    .empty             (empty),
    .out_kind          (out_kind),
    .out_packet_start  (out_packet_start),
    .out_packet_length (out_packet_length),
    .out_timestamp     (out_timestamp),
    .out_run_last      (out_run_last)
  );

endmodule

`default_nettype wire
